FILE: design/sbtp_pkg.sv
// Package for the six-bit text packer: result word type, code and character
// constants, and the character/code translation functions. No dependencies.
package sbtp_pkg;

  localparam logic [5:0] CODE_TERM     = 6'd0;
  localparam logic [5:0] CODE_NEWLINE  = 6'd1;
  localparam logic [5:0] CODE_LETTER_A = 6'd2;
  localparam logic [5:0] CODE_DIGIT0   = 6'd28;
  localparam logic [5:0] CODE_SPACE    = 6'd38;
  localparam logic [5:0] CODE_PERIOD   = 6'd39;
  localparam logic [5:0] CODE_LBRACK   = 6'd40;
  localparam logic [5:0] CODE_RBRACK   = 6'd41;
  localparam logic [5:0] CODE_DASH     = 6'd42;
  localparam logic [5:0] CODE_STAR     = 6'd43;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       string_end;
    logic       run_end;
  } res_t;

  function automatic logic [5:0] encode_char(input logic [7:0] b);
    logic [7:0] u;
    logic [5:0] c;
    u = b;
    if (b >= CH_LOWER_A && b <= CH_LOWER_Z) u = b - CASE_OFFSET;
    case (u) inside
      [CH_ZERO:CH_NINE]:       c = 6'(u - CH_ZERO) + CODE_DIGIT0;
      [CH_UPPER_A:CH_UPPER_Z]: c = 6'(u - CH_UPPER_A) + CODE_LETTER_A;
      CH_NUL:                  c = CODE_TERM;
      CH_NEWLINE:              c = CODE_NEWLINE;
      CH_SPACE:                c = CODE_SPACE;
      CH_PERIOD:               c = CODE_PERIOD;
      CH_LBRACK:               c = CODE_LBRACK;
      CH_RBRACK:               c = CODE_RBRACK;
      CH_DASH:                 c = CODE_DASH;
      default:                 c = CODE_STAR;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] decode_code(input logic [5:0] c);
    logic [7:0] ch;
    case (c) inside
      [CODE_DIGIT0:CODE_DIGIT0 + 6'd9]:    ch = {2'b00, c - CODE_DIGIT0} + CH_ZERO;
      [CODE_LETTER_A:CODE_LETTER_A + 6'd25]: ch = {2'b00, c - CODE_LETTER_A} + CH_UPPER_A;
      CODE_TERM:                           ch = CH_NUL;
      CODE_NEWLINE:                        ch = CH_NEWLINE;
      CODE_SPACE:                          ch = CH_SPACE;
      CODE_PERIOD:                         ch = CH_PERIOD;
      CODE_LBRACK:                         ch = CH_LBRACK;
      CODE_RBRACK:                         ch = CH_RBRACK;
      CODE_DASH:                           ch = CH_DASH;
      default:                             ch = CH_STAR;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/six_bit_text_packer.sv
// Six-bit text packer/unpacker top level: input register, one-pass
// translate logic, two-word result buffer. Depends on sbtp_pkg.
//
// channel | signals                          | dir | handshake
// in      | in_byte                          | in  | in_valid / in_ready
// out     | out_byte, string_end, run_end    | out | out_valid / out_ready
// cfg     | cfg_wr_data (direction)          | in  | cfg_wr_en, no wait
//
// A word is registered on accept and translated, once the result buffer
// has room, into zero, one or two result words. Out sets the pace: a word
// waits until the buffer is empty or its last word is taken, and a new
// word is accepted as it moves on. Reset (rst, synchronous) empties both
// stages and clears pending bits; out stalls back up into in_ready.
module six_bit_text_packer
  import sbtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       string_end,
  output logic       run_end,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic       direction;
  logic [7:0] pending_bits;
  logic [2:0] pending_count;
  logic [7:0] pending_bits_next;
  logic [2:0] pending_count_next;

  logic       in_full;
  logic [7:0] in_q;

  res_t       buf0, buf1;
  logic [1:0] buf_count;
  res_t       r0, r1;
  logic [1:0] n_res;

  logic       pop, proc;

  logic [7:0]  acc;
  logic [5:0]  code;
  logic [12:0] pacc;
  logic [3:0]  ptot;
  logic [15:0] uacc;
  logic [3:0]  utot;
  logic [5:0]  c0, c1;

  assign pop       = out_valid && out_ready;
  assign proc      = in_full && (buf_count == 2'd0 || (buf_count == 2'd1 && pop));
  assign in_ready  = !in_full || proc;
  assign out_valid = buf_count != 2'd0;
  assign out_byte   = buf0.data;
  assign string_end = buf0.string_end;
  assign run_end    = buf0.run_end;

  always_comb begin
    acc  = pending_bits & ((8'd1 << pending_count) - 8'd1);
    code = encode_char(in_q);
    pacc = {5'b0, acc} | ({7'b0, code} << pending_count);
    ptot = {1'b0, pending_count} + 4'd6;
    uacc = {8'b0, acc} | ({8'b0, in_q} << pending_count);
    utot = {1'b0, pending_count} + 4'd8;
    c0   = uacc[5:0];
    c1   = uacc[11:6];

    r0 = '0;
    r1 = '0;
    n_res = 2'd0;
    pending_bits_next  = 8'd0;
    pending_count_next = 3'd0;

    if (direction == DIR_PACK) begin
      if (in_q != CH_NUL) begin
        if (ptot >= 4'd8) begin
          r0.data = pacc[7:0];
          n_res = 2'd1;
          pending_bits_next  = {3'b0, pacc[12:8]};
          pending_count_next = 3'(ptot - 4'd8);
        end else begin
          pending_bits_next  = pacc[7:0];
          pending_count_next = ptot[2:0];
        end
      end else begin
        r0.data = pacc[7:0];
        if (ptot > 4'd8) begin
          r1.data = {3'b0, pacc[12:8]};
          n_res = 2'd2;
        end else begin
          n_res = 2'd1;
        end
      end
    end else begin
      if (c0 == CODE_TERM) begin
        r0.data = CH_NUL;
        r0.string_end = 1'b1;
        n_res = 2'd1;
      end else begin
        r0.data = decode_code(c0);
        if (utot >= 4'd12) begin
          n_res = 2'd2;
          if (c1 == CODE_TERM) begin
            r1.data = CH_NUL;
            r1.string_end = 1'b1;
          end else begin
            r1.data = decode_code(c1);
            pending_bits_next  = {4'b0, uacc[15:12]};
            pending_count_next = 3'(utot - 4'd12);
          end
        end else begin
          n_res = 2'd1;
          pending_bits_next  = uacc[13:6];
          pending_count_next = 3'(utot - 4'd6);
        end
      end
    end

    if (direction == DIR_PACK && in_q == CH_NUL) begin
      if (n_res == 2'd2) r1.string_end = 1'b1;
      else r0.string_end = 1'b1;
    end
    r0.run_end = n_res == 2'd1;
    r1.run_end = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_q <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= DIR_PACK;
      pending_bits  <= 8'd0;
      pending_count <= 3'd0;
    end else if (cfg_wr_en) begin
      direction     <= cfg_wr_data;
      pending_bits  <= 8'd0;
      pending_count <= 3'd0;
    end else if (proc) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 2'd0;
    end else if (proc) begin
      buf_count <= n_res;
    end else if (pop) begin
      buf_count <= buf_count - 2'd1;
    end
    if (proc) begin
      buf0 <= r0;
      buf1 <= r1;
    end else if (pop) begin
      buf0 <= buf1;
    end
  end

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    buf_count != 2'd3)
    else $error("result buffer count out of range");

  a_two_run_end: assert property (@(posedge clk) disable iff (rst)
    buf_count == 2'd2 |-> buf1.run_end && !buf0.run_end)
    else $error("run_end misplaced in result buffer");

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    proc |-> buf_count == 2'd0 || pop)
    else $error("result buffer overwritten");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> pending_count == 3'd0)
    else $error("pending bits survive direction write");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_end)
    else $error("string end not on last word of run");

endmodule
